// ===== hw/rtl/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// Request coalescing table package
// Command and result codes and fixed field widths shared by the table's files.
// ----------------------------------------------------------------------------
package rct_pkg;

    localparam int KEY_W      = 32;
    localparam int SLOT_FW    = 4;
    localparam int REQ_FW     = 8;

    typedef logic [1:0] cmd_t;
    typedef logic [2:0] kind_t;

    localparam cmd_t CMD_LOOKUP  = 2'd0;
    localparam cmd_t CMD_CLOSE   = 2'd1;
    localparam cmd_t CMD_RELEASE = 2'd2;
    localparam cmd_t CMD_NONE    = 2'd3;

    localparam kind_t KIND_JOINED = 3'd0;
    localparam kind_t KIND_OWNER  = 3'd1;
    localparam kind_t KIND_FULL   = 3'd2;
    localparam kind_t KIND_WAITER = 3'd3;
    localparam kind_t KIND_DONE   = 3'd4;

endpackage

// ===== hw/rtl/rct_ram.sv =====
// ----------------------------------------------------------------------------
// Request coalescing table RAM
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/request_coalescing_table_core.sv =====
// ----------------------------------------------------------------------------
// Request coalescing table core
// Coalesces outstanding requests by key: lookup joins or allocates a slot
// or reports a full table; close emits the slot's waiters, release frees the slot.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Slot keys, open flags and waiter
// counts live in a slot RAM read once per cycle, and waiter ids in a waiter
// RAM; only the per-slot valid bits are flip-flops. A lookup streams all
// TABLE_SLOTS entries through the slot RAM, stopping at the first joinable
// slot. A close reads the slot entry, writes it back closed, then reads each
// waiter id in turn through the one read port of the waiter RAM, sending
// each as a result before reading the next; a close with no waiters gives a
// done result. A release clears the slot's valid bit and gives a done result.
// Any result can be held off by out_ready. Commands with code 3, and closes
// or releases with a slot index at or beyond TABLE_SLOTS, are taken and
// produce no result. A new input is taken whenever the previous transaction
// has finished its work, even while its last result still waits in the
// output register.
module request_coalescing_table_core #(
    parameter int TABLE_SLOTS    = 16,
    parameter int MAX_WAITERS    = 8,
    parameter int REQUESTER_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  rct_pkg::cmd_t                      cmd,
    input  logic [rct_pkg::KEY_W-1:0]          key,
    input  logic [rct_pkg::SLOT_FW-1:0]        slot_index,
    input  logic [rct_pkg::REQ_FW-1:0]         requester_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output rct_pkg::kind_t                     kind,
    output logic [rct_pkg::SLOT_FW-1:0]        slot,
    output logic [rct_pkg::REQ_FW-1:0]         requester,
    output logic                               last
);

    import rct_pkg::*;

    localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W    = $clog2(MAX_WAITERS + 1);
    localparam int ENTRY_W  = KEY_W + 1 + CNT_W;
    localparam int OPEN_BIT = CNT_W;
    localparam int WDEPTH   = TABLE_SLOTS * MAX_WAITERS;
    localparam int WADDR_W  = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_WAITERS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_JOIN     = 3'd2;
    localparam logic [2:0] S_ALLOC    = 3'd3;
    localparam logic [2:0] S_CLOSE_RD = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;
    localparam logic [2:0] S_W_READ   = 3'd6;
    localparam logic [2:0] S_W_LOAD   = 3'd7;

    logic [2:0]                state_reg, state_next;
    logic [TABLE_SLOTS-1:0]    slot_valid_reg, slot_valid_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [REQUESTER_BITS-1:0] req_reg, req_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [SLOT_W-1:0]         issue_reg, issue_next;
    logic                      issue_done_reg, issue_done_next;
    logic [SLOT_W-1:0]         chk_reg, chk_next;
    logic                      chk_vld_reg, chk_vld_next;
    logic                      free_found_reg, free_found_next;
    logic [SLOT_W-1:0]         free_reg, free_next;

    logic                      out_valid_reg, out_valid_next;
    kind_t                     kind_reg, kind_next;
    logic [SLOT_W-1:0]         oslot_reg, oslot_next;
    logic [REQ_FW-1:0]         oreq_reg, oreq_next;
    logic                      last_reg, last_next;

    logic                      smem_wr_en, smem_rd_en;
    logic [SLOT_W-1:0]         smem_wr_addr, smem_rd_addr;
    logic [ENTRY_W-1:0]        smem_wr_data, smem_rd_data;
    logic                      wmem_wr_en, wmem_rd_en;
    logic [WADDR_W-1:0]        wmem_wr_addr, wmem_rd_addr;
    logic [REQUESTER_BITS-1:0] wmem_rd_data;

    logic                      accept;
    logic                      out_free;
    logic                      idx_oob;
    logic [SLOT_W-1:0]         in_slot;
    logic [KEY_W-1:0]          rd_key;
    logic                      rd_open;
    logic [CNT_W-1:0]          rd_cnt;
    logic                      chk_valid;
    logic                      hit;
    logic [CNT_W-1:0]          close_cnt;

    rct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (smem_wr_en),
        .wr_addr (smem_wr_addr),
        .wr_data (smem_wr_data),
        .rd_en   (smem_rd_en),
        .rd_addr (smem_rd_addr),
        .rd_data (smem_rd_data)
    );

    rct_ram #(
        .WIDTH (REQUESTER_BITS),
        .DEPTH (WDEPTH)
    ) u_waiter_ram (
        .clk     (clk),
        .wr_en   (wmem_wr_en),
        .wr_addr (wmem_wr_addr),
        .wr_data (req_reg),
        .rd_en   (wmem_rd_en),
        .rd_addr (wmem_rd_addr),
        .rd_data (wmem_rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign idx_oob   = (32'(slot_index) >= 32'(TABLE_SLOTS));
    assign in_slot   = SLOT_W'(slot_index);

    assign rd_key    = smem_rd_data[ENTRY_W-1 -: KEY_W];
    assign rd_open   = smem_rd_data[OPEN_BIT];
    assign rd_cnt    = smem_rd_data[CNT_W-1:0];
    assign chk_valid = slot_valid_reg[chk_reg];
    assign hit       = chk_valid && (rd_key == key_reg) && rd_open && (rd_cnt < CNT_MAX);
    // an invalid slot holds no waiters whatever its RAM entry says
    assign close_cnt = slot_valid_reg[slot_reg] ? rd_cnt : '0;

    // a new owner entry goes to the free slot found by the scan
    assign smem_wr_addr = (state_reg == S_ALLOC) ? free_reg : slot_reg;
    assign wmem_wr_addr = WADDR_W'(slot_reg) * WADDR_W'(MAX_WAITERS) + WADDR_W'(cnt_reg);
    assign wmem_rd_addr = WADDR_W'(slot_reg) * WADDR_W'(MAX_WAITERS) + WADDR_W'(idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        key_next        = key_reg;
        req_next        = req_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        chk_next        = chk_reg;
        chk_vld_next    = 1'b0;
        free_found_next = free_found_reg;
        free_next       = free_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        oslot_next      = oslot_reg;
        oreq_next       = oreq_reg;
        last_next       = last_reg;

        smem_wr_en      = 1'b0;
        smem_wr_data    = {key_reg, 1'b1, CNT_W'(0)};
        smem_rd_en      = 1'b0;
        smem_rd_addr    = issue_reg;
        wmem_wr_en      = 1'b0;
        wmem_rd_en      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next  = key;
                    req_next  = REQUESTER_BITS'(requester_id);
                    slot_next = in_slot;
                    case (cmd)
                        CMD_LOOKUP:
                        begin
                            issue_next      = '0;
                            issue_done_next = 1'b0;
                            free_found_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        CMD_CLOSE:
                        begin
                            if (!idx_oob)
                            begin
                                smem_rd_en   = 1'b1;
                                smem_rd_addr = in_slot;
                                state_next   = S_CLOSE_RD;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (!idx_oob)
                            begin
                                slot_valid_next[in_slot] = 1'b0;
                                state_next               = S_DONE;
                            end
                        end
                        default:
                        begin
                            // drop: no result for an unused command
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // stream one slot entry per cycle; each entry is checked once its registered read data returns
                if (!issue_done_reg)
                begin
                    smem_rd_en   = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_next     = issue_reg;
                    if (issue_reg == LAST_SLOT)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_next = issue_reg + SLOT_W'(1);
                    end
                end
                if (chk_vld_reg)
                begin
                    if (hit)
                    begin
                        slot_next  = chk_reg;
                        cnt_next   = rd_cnt;
                        state_next = S_JOIN;
                    end
                    else
                    begin
                        if (!chk_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_next       = chk_reg;
                        end
                        if (chk_reg == LAST_SLOT)
                        begin
                            state_next = S_ALLOC;
                        end
                    end
                end
            end

            S_JOIN:
            begin
                if (out_free)
                begin
                    smem_wr_en     = 1'b1;
                    smem_wr_data   = {key_reg, 1'b1, cnt_reg + CNT_W'(1)};
                    wmem_wr_en     = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_JOINED;
                    oslot_next     = slot_reg;
                    oreq_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_ALLOC:
            begin
                slot_next = free_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    oreq_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    if (free_found_reg)
                    begin
                        // store the key as an open slot with no waiters
                        smem_wr_en                = 1'b1;
                        slot_valid_next[free_reg] = 1'b1;
                        kind_next                 = KIND_OWNER;
                        oslot_next                = free_reg;
                    end
                    else
                    begin
                        kind_next  = KIND_FULL;
                        oslot_next = '0;
                    end
                end
            end

            S_CLOSE_RD:
            begin
                // write back closed, keep the waiters for a later close
                smem_wr_en   = 1'b1;
                smem_wr_data = {rd_key, 1'b0, rd_cnt};
                cnt_next     = close_cnt;
                idx_next     = '0;
                state_next   = (close_cnt == '0) ? S_DONE : S_W_READ;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_DONE;
                    oslot_next     = slot_reg;
                    oreq_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_W_READ:
            begin
                wmem_rd_en = 1'b1;
                state_next = S_W_LOAD;
            end

            S_W_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_WAITER;
                    oslot_next     = slot_reg;
                    oreq_next      = REQ_FW'(wmem_rd_data);
                    last_next      = (idx_reg + CNT_W'(1) == cnt_reg);
                    idx_next       = idx_reg + CNT_W'(1);
                    state_next     = (idx_reg + CNT_W'(1) == cnt_reg) ? S_IDLE : S_W_READ;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            chk_vld_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
            chk_vld_reg    <= chk_vld_next;
            issue_done_reg <= issue_done_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        req_reg   <= req_next;
        slot_reg  <= slot_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        issue_reg <= issue_next;
        chk_reg   <= chk_next;
        free_reg  <= free_next;
        kind_reg  <= kind_next;
        oslot_reg <= oslot_next;
        oreq_reg  <= oreq_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign slot      = SLOT_FW'(oslot_reg);
    assign requester = oreq_reg;
    assign last      = last_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Request coalescing table testbench
// Drives lookup, close, release and unused transactions through the valid/ready input
// channel and checks every result against a cycle-free model of the table,
// with random idling on both channels and a stretch of steady traffic.
// ----------------------------------------------------------------------------
module tb_top;

    import rct_pkg::*;

    localparam int TABLE_SLOTS    = 16;
    localparam int MAX_WAITERS    = 8;
    localparam int REQUESTER_BITS = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        kind_t              kind;
        logic [SLOT_FW-1:0] slot;
        logic [REQ_FW-1:0]  requester;
        logic               last;
    } table_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic [SLOT_FW-1:0] slot_index;
    logic [REQ_FW-1:0]  requester_id;
    logic               out_valid;
    logic               out_ready;
    kind_t              kind;
    logic [SLOT_FW-1:0] slot;
    logic [REQ_FW-1:0]  requester;
    logic               last;

    // model of the table contents
    logic               tbl_valid [TABLE_SLOTS];
    logic [KEY_W-1:0]   tbl_key   [TABLE_SLOTS];
    logic               tbl_open  [TABLE_SLOTS];
    int unsigned        tbl_count [TABLE_SLOTS];
    logic [REQ_FW-1:0]  tbl_waiter[TABLE_SLOTS][MAX_WAITERS];

    table_result_t      pending_results[$];
    int unsigned        full_seen;
    int unsigned        err_cnt;
    int unsigned        cycle_cnt;
    bit                 steady_flow;
    logic [KEY_W-1:0]   key_pool[6];

    request_coalescing_table_core #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .MAX_WAITERS    (MAX_WAITERS),
        .REQUESTER_BITS (REQUESTER_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .slot_index   (slot_index),
        .requester_id (requester_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot         (slot),
        .requester    (requester),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 22);
    end

    function automatic void push_result(kind_t k, int unsigned s, logic [REQ_FW-1:0] r,
                                        logic l);
        table_result_t res;
        res.kind      = k;
        res.slot      = s[SLOT_FW-1:0];
        res.requester = r;
        res.last      = l;
        pending_results.push_back(res);
    endfunction

    // Update the table model for one accepted transaction and queue its results.
    function automatic void coalesce_predict(cmd_t c, logic [KEY_W-1:0] k,
                                             logic [SLOT_FW-1:0] idx,
                                             logic [REQ_FW-1:0] rid);
        int                free_slot;
        int unsigned       n;
        logic [REQ_FW-1:0] req;
        free_slot = -1;
        req = rid & REQ_FW'((1 << REQUESTER_BITS) - 1);
        if (c == CMD_LOOKUP)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (!tbl_valid[i])
                begin
                    if (free_slot < 0)
                        free_slot = i;
                end
                else if (tbl_key[i] == k && tbl_open[i] && tbl_count[i] < MAX_WAITERS)
                begin
                    tbl_waiter[i][tbl_count[i]] = req;
                    tbl_count[i]++;
                    push_result(KIND_JOINED, i, '0, 1'b1);
                    return;
                end
            end
            if (free_slot < 0)
            begin
                full_seen++;
                push_result(KIND_FULL, 0, '0, 1'b1);
                return;
            end
            tbl_valid[free_slot] = 1'b1;
            tbl_key[free_slot]   = k;
            tbl_open[free_slot]  = 1'b1;
            tbl_count[free_slot] = 0;
            push_result(KIND_OWNER, free_slot, '0, 1'b1);
            return;
        end
        // unused command or out-of-range slot: dropped with no result
        if (c == CMD_NONE || idx >= TABLE_SLOTS)
            return;
        if (c == CMD_CLOSE)
        begin
            n = tbl_count[idx];
            tbl_open[idx] = 1'b0;
            if (n == 0)
                push_result(KIND_DONE, idx, '0, 1'b1);
            for (int unsigned i = 0; i < n; i++)
                push_result(KIND_WAITER, idx, tbl_waiter[idx][i], (i + 1 == n));
            return;
        end
        tbl_valid[idx] = 1'b0;
        tbl_open[idx]  = 1'b0;
        tbl_count[idx] = 0;
        push_result(KIND_DONE, idx, '0, 1'b1);
    endfunction

    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d requester %0d last %0d",
                       kind, slot, requester, last);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                    err_cnt++;
                end
                if (slot !== want.slot)
                begin
                    $error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
                    err_cnt++;
                end
                if (requester !== want.requester)
                begin
                    $error("requester mismatch: expected %0d, actual %0d",
                           want.requester, requester);
                    err_cnt++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, last);
                    err_cnt++;
                end
            end
        end
    end

    // Present one transaction and hold it until accepted; valid stays high after.
    task automatic send_transaction(input cmd_t c, input logic [KEY_W-1:0] k,
                                    input logic [SLOT_FW-1:0] idx,
                                    input logic [REQ_FW-1:0] rid);
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        key          <= k;
        slot_index   <= idx;
        requester_id <= rid;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        coalesce_predict(c, k, idx, rid);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [SLOT_FW-1:0] pick_busy_slot();
        int busy[$];
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (tbl_valid[i])
                busy.push_back(i);
        end
        if (busy.size() == 0 || $urandom_range(0, 99) < 20)
            return SLOT_FW'($urandom_range(0, TABLE_SLOTS - 1));
        return SLOT_FW'(busy[$urandom_range(0, busy.size() - 1)]);
    endfunction

    task automatic test_idle_commands();
        send_transaction(CMD_NONE, '1, '1, '1);
        send_transaction(CMD_CLOSE, '0, 4'd0, '0);
        send_transaction(CMD_RELEASE, '0, 4'd15, '0);
    endtask

    task automatic test_waiter_overflow();
        send_transaction(CMD_LOOKUP, 32'hffff_ffff, '0, 8'h00);
        send_transaction(CMD_LOOKUP, 32'hffff_ffff, '1, 8'hff);
        send_transaction(CMD_LOOKUP, 32'hffff_ffff, '0, 8'h00);
        send_transaction(CMD_LOOKUP, 32'hffff_ffff, '0, 8'ha5);
        send_transaction(CMD_LOOKUP, 32'hffff_ffff, '0, 8'h5a);
        for (int i = 0; i < MAX_WAITERS - 4; i++)
            send_transaction(CMD_LOOKUP, 32'hffff_ffff, '0, REQ_FW'($urandom));
        // slot 0 is now at its waiter limit: allocate a new owner slot
        send_transaction(CMD_LOOKUP, 32'hffff_ffff, '0, 8'h11);
    endtask

    task automatic test_close_repeat();
        send_transaction(CMD_CLOSE, '0, 4'd0, '0);
        send_transaction(CMD_CLOSE, '0, 4'd0, '0);
        send_transaction(CMD_LOOKUP, 32'hffff_ffff, '0, 8'h3c);
        send_transaction(CMD_CLOSE, '0, 4'd1, '0);
        send_transaction(CMD_RELEASE, '0, 4'd0, '0);
        send_transaction(CMD_RELEASE, '0, 4'd1, '0);
        send_transaction(CMD_LOOKUP, 32'h0000_0000, '0, 8'h80);
        send_transaction(CMD_RELEASE, '0, 4'd0, '0);
    endtask

    task automatic test_table_full();
        int unsigned tries;
        tries = 0;
        full_seen = 0;
        while (full_seen < 3 && tries < 48)
        begin
            send_transaction(CMD_LOOKUP, KEY_W'($urandom), SLOT_FW'($urandom),
                             REQ_FW'($urandom));
            tries++;
        end
        for (int i = 0; i < TABLE_SLOTS; i++)
            send_transaction(CMD_RELEASE, KEY_W'($urandom), SLOT_FW'(i), REQ_FW'($urandom));
    endtask

    // Mostly lookups on a small key pool so slots collect waiters, mixed with
    // closes and releases aimed mostly at live slots, plus some unused commands.
    task automatic test_mixed_traffic(input int n_items);
        int               sent;
        int unsigned      pick;
        logic [KEY_W-1:0] k;
        sent = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            key_pool[i] = KEY_W'($urandom);
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_transaction(CMD_NONE, KEY_W'($urandom), SLOT_FW'($urandom),
                                 REQ_FW'($urandom));
            end
            else
            begin
                if (pick < 62)
                begin
                    k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 5)]
                                                     : KEY_W'($urandom);
                    send_transaction(CMD_LOOKUP, k, SLOT_FW'($urandom), REQ_FW'($urandom));
                end
                else if (pick < 85)
                    send_transaction(CMD_CLOSE, KEY_W'($urandom), pick_busy_slot(),
                                     REQ_FW'($urandom));
                else
                    send_transaction(CMD_RELEASE, KEY_W'($urandom), pick_busy_slot(),
                                     REQ_FW'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_NONE;
        key          = '0;
        slot_index   = '0;
        requester_id = '0;
        out_ready    = 1'b0;
        steady_flow  = 1'b0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        full_seen    = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_open[i]  = 1'b0;
            tbl_count[i] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_commands();
        test_waiter_overflow();
        test_close_repeat();
        // hold off new transactions until every pending result is out
        wait_results_drained();
        test_table_full();
        test_mixed_traffic(70);
        wait_results_drained();
        steady_flow = 1'b1;
        test_mixed_traffic(50);
        wait_results_drained();
        steady_flow = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rct_pkg.sv
hw/rtl/rct_ram.sv
hw/rtl/request_coalescing_table_core.sv
tb/sv/tb_top.sv
